// ----- sv/lwbsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU write-back sector cache package
// Shared sizes, operation codes, controller states and cell structures.
// ----------------------------------------------------------------------------
package lwbsc_pkg;

    localparam int ENTRIES      = 64;
    localparam int SECTOR_BYTES = 512;
    localparam int MAX_RESULTS  = 64;

    localparam int SECTOR_W   = 32;
    localparam int BYTES_W    = 10;
    localparam int FUNC_W     = 2;
    localparam int SLOT_OUT_W = 6;
    localparam int SLOT_W     = $clog2(ENTRIES);
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FLUSH
    } ctrl_state_t;

    // Contents of one rank position of the recency chain.
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [SECTOR_W-1:0] tag;
        logic                valid;
        logic                dirty;
    } cell_entry_t;

    // Per-cell commands from the controller.
    typedef struct packed {
        logic shift;
        logic clean;
    } cell_ctrl_t;

endpackage

// ----- sv/lwbsc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU sector cache cell
// Holds the slot at one recency rank and compares its tag with the request.
// ----------------------------------------------------------------------------
module lwbsc_cell import lwbsc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cell_ctrl_t          ctrl,
    input  cell_entry_t         entry_in,
    input  logic [SLOT_W-1:0]   reset_slot,
    input  logic [SECTOR_W-1:0] lookup_sector,
    output cell_entry_t         entry_out,
    output logic                match
);

    cell_entry_t entry_reg;
    cell_entry_t entry_next;

    // Take the neighbour's entry on a shift, or drop the dirty mark on a clean.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.shift) begin
            entry_next = entry_in;
        end else if (ctrl.clean) begin
            entry_next.dirty = 1'b0;
        end
    end

    // Slot identity and marks reset; the tag is only read once valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.slot  <= reset_slot;
            entry_reg.valid <= 1'b0;
            entry_reg.dirty <= 1'b0;
            entry_reg.tag   <= entry_next.tag;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry_out = entry_reg;
    assign match     = entry_reg.valid && (entry_reg.tag == lookup_sector);

endmodule

// ----- sv/lru_write_back_sector_cache_top.sv -----
`timescale 1ns / 1ps
// Read or write request: the transfer is registered, the ST_SCAN state scans the cell
// chain rank by rank, then ST_UPDATE shifts the chain and loads the output register.
// Flush: one result per dirty slot; the scan waits whenever the output stalls.
// One request in flight at a time; the rank scan sets the rate.
// Reset (synchronous, active low) empties every slot and sets slot i to rank i.
// ----------------------------------------------------------------------------
// LRU write-back sector cache top level
// Tag and replacement controller over a chain of rank-ordered cells.
// ----------------------------------------------------------------------------
module lru_write_back_sector_cache_top import lwbsc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [SECTOR_W-1:0]   s_sector,
    input  logic [BYTES_W-1:0]    s_byte_count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_OUT_W-1:0] m_slot,
    output logic                  m_hit,
    output logic                  m_fetch,
    output logic                  m_writeback,
    output logic [SECTOR_W-1:0]   m_writeback_sector,
    output logic [BYTES_W-1:0]    m_zero_from,
    output logic                  m_last
);

    ctrl_state_t state_reg, state_next;

    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]    hit_pos_reg, hit_pos_next;
    logic                empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]    empty_pos_reg, empty_pos_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                  m_valid_reg, m_valid_next;
    logic [SLOT_OUT_W-1:0] m_slot_reg, m_slot_next;
    logic                  m_hit_reg, m_hit_next;
    logic                  m_fetch_reg, m_fetch_next;
    logic                  m_wb_reg, m_wb_next;
    logic [SECTOR_W-1:0]   m_wb_sector_reg, m_wb_sector_next;
    logic [BYTES_W-1:0]    m_zero_reg, m_zero_next;
    logic                  m_last_reg, m_last_next;

    cell_entry_t         entries [ENTRIES];
    cell_entry_t         chain_in [ENTRIES];
    cell_ctrl_t          cell_ctrl [ENTRIES];
    logic [ENTRIES-1:0]  match_vec;
    logic [ENTRIES-1:0]  dirty_vec;
    logic [ENTRIES-1:0]  later_dirty;

    logic                out_free;
    logic                idx_last;
    logic [IDX_W-1:0]    upd_pos;
    logic [IDX_W-1:0]    sel_pos;
    cell_entry_t         sel_entry;
    cell_entry_t         new_entry;
    logic                flush_due;
    logic                do_update;
    logic                do_flush_emit;
    logic                accept;

    // Row of cells, rank 0 first; each cell shifts from its lower-rank neighbour.
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign chain_in[k] = new_entry;
        end else begin : g_body
            assign chain_in[k] = entries[k-1];
        end
        lwbsc_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (cell_ctrl[k]),
            .entry_in      (chain_in[k]),
            .reset_slot    (SLOT_W'(k)),
            .lookup_sector (sector_reg),
            .entry_out     (entries[k]),
            .match         (match_vec[k])
        );
        assign dirty_vec[k] = entries[k].valid && entries[k].dirty;
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign idx_last  = (idx_reg == IDX_W'(ENTRIES - 1));
    assign accept    = s_valid && s_ready;

    // A hit wins, then the most recent empty slot, then the least recent slot.
    assign upd_pos   = hit_found_reg   ? hit_pos_reg   :
                       empty_found_reg ? empty_pos_reg : IDX_W'(ENTRIES - 1);
    assign sel_pos   = (state_reg == ST_FLUSH) ? idx_reg : upd_pos;
    assign sel_entry = entries[sel_pos];
    assign flush_due = dirty_vec[idx_reg] && (cnt_reg < CNT_W'(MAX_RESULTS));

    // Entry that enters rank 0 on an update.
    always_comb begin
        new_entry.slot  = sel_entry.slot;
        new_entry.tag   = sector_reg;
        new_entry.valid = 1'b1;
        new_entry.dirty = (func_reg == FUNC_WRITE) || (hit_found_reg && sel_entry.dirty);
    end

    // Dirty slots ranked after the current flush position.
    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            later_dirty[j] = dirty_vec[j] && (j > int'(idx_reg));
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == FUNC_FLUSH) begin
                        state_next = ST_FLUSH;
                    end else if (s_func == FUNC_READ || s_func == FUNC_WRITE) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (idx_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (idx_last && !(flush_due && !out_free)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        s_ready       = 1'b0;
        do_update     = 1'b0;
        do_flush_emit = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready       = 1'b1;
            ST_SCAN:   s_ready       = 1'b0;
            ST_UPDATE: do_update     = out_free;
            ST_FLUSH:  do_flush_emit = flush_due && out_free;
            default:   s_ready       = 1'b0;
        endcase
    end

    // Cell commands: shift ranks 0..upd_pos on an update, clean on a flush.
    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            cell_ctrl[j].shift = do_update && (j <= int'(upd_pos));
            cell_ctrl[j].clean = do_flush_emit && (j == int'(idx_reg));
        end
    end

    // Request registers, scan bookkeeping and the output register.
    always_comb begin
        func_next        = func_reg;
        sector_next      = sector_reg;
        bytes_next       = bytes_reg;
        idx_next         = idx_reg;
        hit_found_next   = hit_found_reg;
        hit_pos_next     = hit_pos_reg;
        empty_found_next = empty_found_reg;
        empty_pos_next   = empty_pos_reg;
        cnt_next         = cnt_reg;

        m_valid_next     = m_valid_reg && !m_ready;
        m_slot_next      = m_slot_reg;
        m_hit_next       = m_hit_reg;
        m_fetch_next     = m_fetch_reg;
        m_wb_next        = m_wb_reg;
        m_wb_sector_next = m_wb_sector_reg;
        m_zero_next      = m_zero_reg;
        m_last_next      = m_last_reg;

        if (accept) begin
            func_next        = s_func;
            sector_next      = s_sector;
            bytes_next       = s_byte_count;
            idx_next         = '0;
            hit_found_next   = 1'b0;
            empty_found_next = 1'b0;
            cnt_next         = '0;
        end

        if (state_reg == ST_SCAN) begin
            if (match_vec[idx_reg]) begin
                hit_found_next = 1'b1;
                hit_pos_next   = idx_reg;
            end
            if (!entries[idx_reg].valid && !empty_found_reg) begin
                empty_found_next = 1'b1;
                empty_pos_next   = idx_reg;
            end
            idx_next = idx_reg + 1'b1;
        end

        if (do_update) begin
            m_valid_next     = 1'b1;
            m_slot_next      = SLOT_OUT_W'(sel_entry.slot);
            m_hit_next       = hit_found_reg;
            m_fetch_next     = !hit_found_reg && (func_reg == FUNC_READ);
            m_wb_next        = !hit_found_reg && !empty_found_reg && sel_entry.dirty;
            m_wb_sector_next = m_wb_next ? sel_entry.tag : '0;
            if (func_reg == FUNC_READ) begin
                m_zero_next = (bytes_reg > BYTES_W'(SECTOR_BYTES)) ?
                              BYTES_W'(SECTOR_BYTES) : bytes_reg;
            end else begin
                m_zero_next = '0;
            end
            m_last_next      = 1'b1;
        end

        if (state_reg == ST_FLUSH) begin
            if (do_flush_emit) begin
                m_valid_next     = 1'b1;
                m_slot_next      = SLOT_OUT_W'(sel_entry.slot);
                m_hit_next       = 1'b0;
                m_fetch_next     = 1'b0;
                m_wb_next        = 1'b1;
                m_wb_sector_next = sel_entry.tag;
                m_zero_next      = '0;
                m_last_next      = !(|later_dirty) ||
                                   (cnt_reg == CNT_W'(MAX_RESULTS - 1));
                cnt_next         = cnt_reg + 1'b1;
            end
            if (!(flush_due && !out_free)) begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        func_reg        <= func_next;
        sector_reg      <= sector_next;
        bytes_reg       <= bytes_next;
        idx_reg         <= idx_next;
        hit_found_reg   <= hit_found_next;
        hit_pos_reg     <= hit_pos_next;
        empty_found_reg <= empty_found_next;
        empty_pos_reg   <= empty_pos_next;
        cnt_reg         <= cnt_next;
        m_slot_reg      <= m_slot_next;
        m_hit_reg       <= m_hit_next;
        m_fetch_reg     <= m_fetch_next;
        m_wb_reg        <= m_wb_next;
        m_wb_sector_reg <= m_wb_sector_next;
        m_zero_reg      <= m_zero_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_slot             = m_slot_reg;
    assign m_hit              = m_hit_reg;
    assign m_fetch            = m_fetch_reg;
    assign m_writeback        = m_wb_reg;
    assign m_writeback_sector = m_wb_sector_reg;
    assign m_zero_from        = m_zero_reg;
    assign m_last             = m_last_reg;

`ifndef SYNTHESIS
    // A valid sector is held by at most one slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> $countones(match_vec) <= 1)
        else $error("sector cached in more than one slot");

    // The rank scan advances by one position every cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && !idx_last |=> idx_reg == $past(idx_reg) + 1'b1)
        else $error("rank scan did not advance");

    // A result never reports both a hit and a fetch.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_hit_reg && m_fetch_reg))
        else $error("result with both hit and fetch");
`endif

endmodule

// ----- sim/lru_write_back_sector_cache_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU write-back sector cache checker
// Watches both channels, predicts each result from its own copy of the slot
// tags, valid and dirty marks and recency ranks, and counts mismatches.
// ----------------------------------------------------------------------------
module lru_write_back_sector_cache_checker import lwbsc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [SECTOR_W-1:0]   s_sector,
    input  logic [BYTES_W-1:0]    s_byte_count,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [SLOT_OUT_W-1:0] m_slot,
    input  logic                  m_hit,
    input  logic                  m_fetch,
    input  logic                  m_writeback,
    input  logic [SECTOR_W-1:0]   m_writeback_sector,
    input  logic [BYTES_W-1:0]    m_zero_from,
    input  logic                  m_last,
    output int                    error_count,
    output int                    pending_count
);

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  hit;
        logic                  fetch;
        logic                  writeback;
        logic [SECTOR_W-1:0]   writeback_sector;
        logic [BYTES_W-1:0]    zero_from;
        logic                  last;
    } cache_result_t;

    logic [SECTOR_W-1:0] tag_mirror   [ENTRIES];
    logic                valid_mirror [ENTRIES];
    logic                dirty_mirror [ENTRIES];
    int                  rank_mirror  [ENTRIES];
    cache_result_t       expected_results [$];

    assign pending_count = expected_results.size();

    // Promote a slot to most recently used.
    function automatic void promote_slot(int s);
        int r;
        r = rank_mirror[s];
        for (int i = 0; i < ENTRIES; i++)
            if (rank_mirror[i] < r) rank_mirror[i]++;
        rank_mirror[s] = 0;
    endfunction

    // Work out the results caused by one accepted request.
    function automatic void predict_access(logic [FUNC_W-1:0] op, logic [SECTOR_W-1:0] sec,
                                           logic [BYTES_W-1:0] nbytes);
        cache_result_t res;
        int            s;
        int            count;
        bit            found;
        res   = '0;
        s     = -1;
        count = 0;
        found = 0;
        if (op == FUNC_FLUSH) begin
            // Dirty slots are reported most recent first.
            for (int r = 0; r < ENTRIES && count < MAX_RESULTS; r++) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (rank_mirror[i] == r && valid_mirror[i] && dirty_mirror[i]) begin
                        res                  = '0;
                        res.slot             = i[SLOT_OUT_W-1:0];
                        res.writeback        = 1'b1;
                        res.writeback_sector = tag_mirror[i];
                        dirty_mirror[i]      = 1'b0;
                        expected_results.push_back(res);
                        count++;
                        break;
                    end
                end
            end
            if (count > 0) expected_results[$].last = 1'b1;
            return;
        end
        if (op != FUNC_READ && op != FUNC_WRITE) return;

        for (int i = 0; i < ENTRIES; i++) begin
            if (valid_mirror[i] && tag_mirror[i] == sec) begin
                s     = i;
                found = 1;
                break;
            end
        end
        if (found) begin
            res.hit = 1'b1;
        end else begin
            // Prefer the most recently ranked empty slot, else evict the oldest.
            for (int i = 0; i < ENTRIES; i++)
                if (!valid_mirror[i] && (s < 0 || rank_mirror[i] < rank_mirror[s])) s = i;
            if (s < 0) begin
                s = 0;
                for (int i = 1; i < ENTRIES; i++)
                    if (rank_mirror[i] > rank_mirror[s]) s = i;
                if (dirty_mirror[s]) begin
                    res.writeback        = 1'b1;
                    res.writeback_sector = tag_mirror[s];
                end
            end
            valid_mirror[s] = 1'b1;
            tag_mirror[s]   = sec;
            dirty_mirror[s] = 1'b0;
            res.fetch       = (op == FUNC_READ);
        end
        promote_slot(s);
        if (op == FUNC_WRITE) dirty_mirror[s] = 1'b1;
        else res.zero_from = (nbytes > SECTOR_BYTES) ? BYTES_W'(SECTOR_BYTES) : nbytes;
        res.slot = s[SLOT_OUT_W-1:0];
        res.last = 1'b1;
        expected_results.push_back(res);
    endfunction

    // Predict on each input transfer and compare each output transfer.
    always @(posedge aclk) begin
        cache_result_t got;
        cache_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tag_mirror[i]   = '0;
                valid_mirror[i] = 1'b0;
                dirty_mirror[i] = 1'b0;
                rank_mirror[i]  = i;
            end
            expected_results.delete();
            error_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_slot, m_hit, m_fetch, m_writeback, m_writeback_sector,
                       m_zero_from, m_last};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, got);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, want, got);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) predict_access(s_func, s_sector, s_byte_count);
        end
    end

endmodule

// ----- sim/lru_write_back_sector_cache_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU write-back sector cache testbench
// Drives directed and random requests with random idling on both channels,
// a long output hold-off to fill the block, and gives the final verdict.
// ----------------------------------------------------------------------------
module lru_write_back_sector_cache_top_tb;
    import lwbsc_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_REQUESTS = 360;
    localparam int HOLD_OFF_LEN = 400;
    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [FUNC_W-1:0]     s_func;
    logic [SECTOR_W-1:0]   s_sector;
    logic [BYTES_W-1:0]    s_byte_count;
    logic                  m_valid;
    logic                  m_ready;
    logic [SLOT_OUT_W-1:0] m_slot;
    logic                  m_hit;
    logic                  m_fetch;
    logic                  m_writeback;
    logic [SECTOR_W-1:0]   m_writeback_sector;
    logic [BYTES_W-1:0]    m_zero_from;
    logic                  m_last;
    int                    error_count;
    int                    pending_count;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    logic                  hold_off_go;
    int                    quiet_cycles;
    logic [SECTOR_W-1:0]   sector_pool [16];

    lru_write_back_sector_cache_top dut (.*);

    lru_write_back_sector_cache_checker checker_inst (.*);

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stalls, plus one counted hold-off when requested.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one request and wait for its transfer.
    task automatic send_request(logic [FUNC_W-1:0] op, logic [SECTOR_W-1:0] sec,
                                logic [BYTES_W-1:0] nbytes);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= op;
        s_sector     <= sec;
        s_byte_count <= nbytes;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Random request: mostly reads and writes over a small sector pool.
    task automatic send_random();
        int                  pick;
        logic [FUNC_W-1:0]   op;
        logic [SECTOR_W-1:0] sec;
        logic [BYTES_W-1:0]  nbytes;
        pick = $urandom_range(99);
        if (pick < 45) op = FUNC_READ;
        else if (pick < 90) op = FUNC_WRITE;
        else if (pick < 97) op = FUNC_FLUSH;
        else op = FUNC_UNKNOWN;
        sec = ($urandom_range(3) == 0) ? $urandom() : sector_pool[$urandom_range(15)]
              + $urandom_range(79);
        nbytes = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(512);
        send_request(op, sec, nbytes);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_func        = FUNC_READ;
        s_sector      = '0;
        s_byte_count  = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_go   = 1'b0;
        for (int i = 0; i < 16; i++) sector_pool[i] = $urandom();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, hits, flush with nothing dirty, unknown code.
        send_request(FUNC_FLUSH, '0, '0);
        send_request(FUNC_UNKNOWN, 32'hFFFF_FFFE, 10'h3FF);
        send_request(FUNC_READ, 32'h0000_0000, 10'd0);
        send_request(FUNC_READ, 32'hFFFF_FFFF, 10'h3FF);
        send_request(FUNC_WRITE, 32'hFFFF_FFFE, 10'd512);
        send_request(FUNC_READ, 32'h0000_0000, 10'd513);
        send_request(FUNC_WRITE, 32'hFFFF_FFFF, 10'd511);
        send_request(FUNC_READ, 32'hFFFF_FFFE, 10'd512);
        send_request(FUNC_FLUSH, 32'hFFFF_FFFF, 10'h3FF);
        send_request(FUNC_FLUSH, '0, '0);
        send_request(FUNC_WRITE, 32'h5555_AAAA, 10'h2AA);
        send_request(FUNC_READ, 32'hAAAA_5555, 10'h155);

        // Fill the cache with dirty slots and overflow it to force evictions.
        for (int i = 0; i < ENTRIES + 8; i++)
            send_request(FUNC_WRITE, 32'h1000 + i, 10'd1);
        // Long receiver hold-off while requests keep coming.
        hold_off_go <= 1'b1;
        for (int i = 0; i < 8; i++) send_request(FUNC_READ, 32'h2000 + i, 10'd7);
        // Full flush of all dirty slots.
        send_request(FUNC_FLUSH, '0, '0);

        // Random traffic in three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 58 : 0;
            recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 23 : 0;
            for (int n = 0; n < RANDOM_REQUESTS / 3; n++) send_random();
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then allow the scan latency to pass.
        while (pending_count != 0) @(posedge aclk);
        repeat (ENTRIES * 4) @(posedge aclk);
        if (error_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/lwbsc_pkg.sv
sv/lwbsc_cell.sv
sv/lru_write_back_sector_cache_top.sv
sim/lru_write_back_sector_cache_checker.sv
sim/lru_write_back_sector_cache_top_tb.sv
